// ===== sv/rsd_pkg.sv =====
// shared types and constants for the rdp state command decoder
package rsd_pkg;

	// operation codes
	localparam logic [1:0] OPR_APPLY = 2'd0;
	localparam logic [1:0] OPR_READ  = 2'd1;
	localparam logic [1:0] OPR_CLEAR = 2'd2;

	// rdp opcodes
	localparam logic [7:0] OPC_OTHER_MODES = 8'h2F;
	localparam logic [7:0] OPC_COMBINE     = 8'h3C;
	localparam logic [7:0] OPC_SCISSOR     = 8'h2D;
	localparam logic [7:0] OPC_COLOR_IMAGE = 8'h3F;
	localparam logic [7:0] OPC_DEPTH_IMAGE = 8'h3E;
	localparam logic [7:0] OPC_PRIM_COLOR  = 8'h3A;
	localparam logic [7:0] OPC_ENV_COLOR   = 8'h3B;
	localparam logic [7:0] OPC_BLEND_COLOR = 8'h39;
	localparam logic [7:0] OPC_FOG_COLOR   = 8'h38;
	localparam logic [7:0] OPC_FILL_COLOR  = 8'h37;
	localparam logic [7:0] OPC_PRIM_DEPTH  = 8'h2E;
	localparam logic [7:0] OPC_CONVERT     = 8'h2C;
	localparam logic [7:0] OPC_KEY_R       = 8'h2B;
	localparam logic [7:0] OPC_KEY_GB      = 8'h2A;
	localparam logic [7:0] OPC_LOAD_SYNC   = 8'h26;
	localparam logic [7:0] OPC_PIPE_SYNC   = 8'h27;
	localparam logic [7:0] OPC_TILE_SYNC   = 8'h28;
	localparam logic [7:0] OPC_FULL_SYNC   = 8'h29;

	// state word kinds, also the changed flag bit of each
	localparam int NUM_WORDS = 14;
	localparam logic [3:0] KIND_OTHER_MODES = 4'd0;
	localparam logic [3:0] KIND_COMBINE     = 4'd1;
	localparam logic [3:0] KIND_SCISSOR     = 4'd2;
	localparam logic [3:0] KIND_COLOR_IMAGE = 4'd3;
	localparam logic [3:0] KIND_DEPTH_IMAGE = 4'd4;
	localparam logic [3:0] KIND_PRIM_COLOR  = 4'd5;
	localparam logic [3:0] KIND_ENV_COLOR   = 4'd6;
	localparam logic [3:0] KIND_BLEND_COLOR = 4'd7;
	localparam logic [3:0] KIND_FOG_COLOR   = 4'd8;
	localparam logic [3:0] KIND_FILL_COLOR  = 4'd9;
	localparam logic [3:0] KIND_PRIM_DEPTH  = 4'd10;
	localparam logic [3:0] KIND_CONVERT     = 4'd11;
	localparam logic [3:0] KIND_KEY_R       = 4'd12;
	localparam logic [3:0] KIND_KEY_GB      = 4'd13;

	localparam int NUM_SYNCS      = 4;
	localparam int SYNC_FLAG_BASE = 14;
	localparam int FLAG_BITS      = 18;
	localparam int WORD_BITS      = 56;

	// read indexes
	localparam logic [4:0] IDX_EPOCH      = 5'd14;
	localparam logic [4:0] IDX_SYNC_FIRST = 5'd15;
	localparam logic [4:0] IDX_SYNC_LAST  = 5'd18;

	localparam logic [31:0] ADDR_MASK = 32'h00FF_FFFF;

	// what the back end does with one queued command
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_WORD,
		CMD_SYNC,
		CMD_TAG,
		CMD_READ,
		CMD_CLEAR
	} rsd_cls_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic        is_rdp;
		logic [7:0]  opcode;
		logic [31:0] word_high;
		logic [31:0] word_low;
		logic [31:0] packet_tag;
		logic [4:0]  read_index;
	} rsd_in_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [17:0] changed_flags_out;
		logic [31:0] epoch_out;
		logic [31:0] last_tag_out;
		logic [1:0]  cycle_mode;
	} rsd_out_t;

	typedef struct packed {
		rsd_cls_t              cls;
		logic [3:0]            kind;
		logic [1:0]            sync_sel;
		logic [WORD_BITS-1:0]  value;
		logic [31:0]           tag;
		logic [4:0]            read_index;
	} rsd_cmd_t;

endpackage

// ===== sv/rsd_front.sv =====
// front end: classifies an incoming transfer and slices the command words
module rsd_front (
	input  rsd_pkg::rsd_in_t  item,
	output rsd_pkg::rsd_cmd_t cmd
);
	import rsd_pkg::*;

	logic [31:0] w0;
	logic [31:0] w1;
	logic [12:0] width_p1;

	assign w0 = item.word_high;
	assign w1 = item.word_low;
	assign width_p1 = {1'b0, w0[11:0]} + 13'd1;

	always_comb begin
		cmd            = '0;
		cmd.cls        = CMD_NOP;
		cmd.tag        = item.packet_tag;
		cmd.read_index = item.read_index;
		cmd.sync_sel   = item.opcode[1:0] - 2'd2;
		case (item.operation)
			OPR_APPLY: begin
				if (item.is_rdp) begin
					cmd.cls = CMD_WORD;
					case (item.opcode)
						OPC_OTHER_MODES: begin
							cmd.kind  = KIND_OTHER_MODES;
							cmd.value = {w0[23:0], w1};
						end
						OPC_COMBINE: begin
							cmd.kind  = KIND_COMBINE;
							cmd.value = {w0[23:0], w1};
						end
						OPC_SCISSOR: begin
							cmd.kind  = KIND_SCISSOR;
							cmd.value = WORD_BITS'({w1[25:24], w0[23:14], w0[11:2],
								w1[23:14], w1[11:2]});
						end
						OPC_COLOR_IMAGE: begin
							cmd.kind  = KIND_COLOR_IMAGE;
							cmd.value = WORD_BITS'({w0[23:21], w0[20:19], width_p1,
								w1[23:0]});
						end
						OPC_DEPTH_IMAGE: begin
							cmd.kind  = KIND_DEPTH_IMAGE;
							cmd.value = WORD_BITS'(w1 & ADDR_MASK);
						end
						OPC_PRIM_COLOR: begin
							cmd.kind  = KIND_PRIM_COLOR;
							cmd.value = WORD_BITS'({w0[12:8], w0[7:0], w1});
						end
						OPC_ENV_COLOR: begin
							cmd.kind  = KIND_ENV_COLOR;
							cmd.value = WORD_BITS'(w1);
						end
						OPC_BLEND_COLOR: begin
							cmd.kind  = KIND_BLEND_COLOR;
							cmd.value = WORD_BITS'(w1);
						end
						OPC_FOG_COLOR: begin
							cmd.kind  = KIND_FOG_COLOR;
							cmd.value = WORD_BITS'(w1);
						end
						OPC_FILL_COLOR: begin
							cmd.kind  = KIND_FILL_COLOR;
							cmd.value = WORD_BITS'(w1);
						end
						OPC_PRIM_DEPTH: begin
							cmd.kind  = KIND_PRIM_DEPTH;
							cmd.value = WORD_BITS'(w1);
						end
						OPC_CONVERT: begin
							cmd.kind  = KIND_CONVERT;
							cmd.value = WORD_BITS'({w0[21:13], w0[12:4], w0[3:0],
								w1[31:27], w1[26:0]});
						end
						OPC_KEY_R: begin
							cmd.kind  = KIND_KEY_R;
							cmd.value = WORD_BITS'(w1[27:0]);
						end
						OPC_KEY_GB: begin
							cmd.kind  = KIND_KEY_GB;
							cmd.value = {w0[23:0], w1};
						end
						OPC_LOAD_SYNC, OPC_PIPE_SYNC, OPC_TILE_SYNC, OPC_FULL_SYNC: begin
							cmd.cls = CMD_SYNC;
						end
						default: begin
							cmd.cls = CMD_TAG;
						end
					endcase
				end
			end
			OPR_READ: begin
				cmd.cls = CMD_READ;
			end
			OPR_CLEAR: begin
				cmd.cls = CMD_CLEAR;
			end
			default: begin
				cmd.cls = CMD_NOP;
			end
		endcase
	end

endmodule

// ===== sv/rsd_queue.sv =====
// two-entry command queue between front end and back end
module rsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rsd_pkg::rsd_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rsd_pkg::rsd_cmd_t pop_data
);
	import rsd_pkg::*;

	rsd_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/rsd_back.sv =====
// back end: render-state register file, sync counters and result register
module rsd_back #(
	parameter int COUNT_BITS = 32,
	parameter int TAG_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rsd_pkg::rsd_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsd_pkg::rsd_out_t rsp
);
	import rsd_pkg::*;

	logic [WORD_BITS-1:0]  words_q  [NUM_WORDS];
	logic [COUNT_BITS-1:0] counts_q [NUM_SYNCS];
	logic [TAG_BITS-1:0]   tags_q   [NUM_SYNCS];
	logic [COUNT_BITS-1:0] epoch_q;
	logic [FLAG_BITS-1:0]  flags_q;
	logic [TAG_BITS-1:0]   last_tag_q;

	logic [WORD_BITS-1:0]  words_d  [NUM_WORDS];
	logic [COUNT_BITS-1:0] counts_d [NUM_SYNCS];
	logic [TAG_BITS-1:0]   tags_d   [NUM_SYNCS];
	logic [COUNT_BITS-1:0] epoch_d;
	logic [FLAG_BITS-1:0]  flags_d;
	logic [TAG_BITS-1:0]   last_tag_d;

	logic                           pop;
	logic [TAG_BITS-1:0]            cmd_tag;
	logic [1:0]                     read_sel;
	logic [COUNT_BITS+TAG_BITS-1:0] sync_cat;
	logic [127:0]                   sync_wide;
	logic [63:0]                    rd_data;
	logic                           rsp_valid_q;
	rsd_out_t                       rsp_q;

	assign pop       = cmd_valid && cmd_ready;
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cmd_tag   = TAG_BITS'(cmd.tag);

	// read side, on the state before this command
	assign read_sel  = 2'(cmd.read_index - IDX_SYNC_FIRST);
	assign sync_cat  = {counts_q[read_sel], tags_q[read_sel]};
	assign sync_wide = 128'(sync_cat);

	always_comb begin
		rd_data = '0;
		if (cmd.read_index < IDX_EPOCH) begin
			rd_data = 64'(words_q[cmd.read_index[3:0]]);
		end else if (cmd.read_index == IDX_EPOCH) begin
			rd_data = 64'(epoch_q);
		end else if (cmd.read_index <= IDX_SYNC_LAST) begin
			rd_data = sync_wide[63:0];
		end
	end

	// next state
	always_comb begin
		words_d    = words_q;
		counts_d   = counts_q;
		tags_d     = tags_q;
		epoch_d    = epoch_q;
		flags_d    = flags_q;
		last_tag_d = last_tag_q;
		case (cmd.cls)
			CMD_WORD: begin
				words_d[cmd.kind] = cmd.value;
				flags_d    = flags_q | (FLAG_BITS'(1) << cmd.kind);
				last_tag_d = cmd_tag;
			end
			CMD_SYNC: begin
				epoch_d                = epoch_q + COUNT_BITS'(1);
				counts_d[cmd.sync_sel] = counts_q[cmd.sync_sel] + COUNT_BITS'(1);
				tags_d[cmd.sync_sel]   = cmd_tag;
				flags_d    = flags_q | (FLAG_BITS'(1) << (SYNC_FLAG_BASE + cmd.sync_sel));
				last_tag_d = cmd_tag;
			end
			CMD_TAG: begin
				last_tag_d = cmd_tag;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NUM_WORDS; i++) words_d[i] = '0;
				for (int i = 0; i < NUM_SYNCS; i++) begin
					counts_d[i] = '0;
					tags_d[i]   = '0;
				end
				epoch_d    = '0;
				flags_d    = '0;
				last_tag_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) words_q[i] <= '0;
			for (int i = 0; i < NUM_SYNCS; i++) begin
				counts_q[i] <= '0;
				tags_q[i]   <= '0;
			end
			epoch_q     <= '0;
			flags_q     <= '0;
			last_tag_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				words_q    <= words_d;
				counts_q   <= counts_d;
				tags_q     <= tags_d;
				epoch_q    <= epoch_d;
				flags_q    <= flags_d;
				last_tag_q <= last_tag_d;
			end
			if (pop) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q.read_data         <= (cmd.cls == CMD_READ) ? rd_data : 64'd0;
			rsp_q.changed_flags_out <= flags_d;
			rsp_q.epoch_out         <= 32'(epoch_d);
			rsp_q.last_tag_out      <= 32'(last_tag_d);
			rsp_q.cycle_mode        <= words_d[KIND_OTHER_MODES][53:52];
		end
	end

endmodule

// ===== sv/rdp_state_command_decoder_core.sv =====
// top level of the rdp state command decoder
// Takes one command transfer per cycle while the queue has room and answers each
// with exactly one result transfer, in order. A command is decoded and sliced by
// the front end as it is accepted, waits in a two-entry queue, and is carried out
// by the back end, which holds the render-state register file and registers the
// result; one command is retired per cycle, so the sustained rate is one item per
// clock, as long as the result side does not stall. The back end's
// single update of the state registers per cycle sets that rate. A result reflects
// the state after its own command. Sync counters and the epoch are COUNT_BITS wide
// and wrap; sync tags and the last tag are kept to TAG_BITS. No clearing pass is
// needed: all state is in flip-flops that reset and the clear operation zero at once.
module rdp_state_command_decoder_core #(
	parameter int COUNT_BITS = 32,
	parameter int TAG_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rsd_pkg::rsd_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsd_pkg::rsd_out_t rsp
);
	import rsd_pkg::*;

	// decoded command leaving the front end
	rsd_cmd_t front_cmd;
	// queue head toward the back end
	rsd_cmd_t head_cmd;
	logic     head_valid;
	logic     head_ready;

	// items accepted whose result has not yet been transferred
	logic [1:0] pend_q;
	logic       cmd_fire;
	logic       rsp_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	rsd_front u_front (
		.item (cmd),
		.cmd  (front_cmd)
	);

	// the queue lets the front accept while the back waits on the result side
	rsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_ready (cmd_ready),
		.push_data  (front_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_cmd)
	);

	rsd_back #(
		.COUNT_BITS (COUNT_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd_ready (head_ready),
		.cmd       (head_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// outstanding count, at most two queued plus one in the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, cmd_fire} - {1'b0, rsp_fire};
		end
	end

	// a result is never shown with nothing outstanding
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) |-> !rsp_valid)
		else $error("result valid with no outstanding command");

	// on an empty block a transfer reaches rsp_valid through the queue and result register
	a_empty_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && pend_q == 2'd0) |-> ##2 rsp_valid)
		else $error("result missing two cycles after transfer into empty block");

	// input is refused only when the queue and result register are busy
	a_ready_when_light: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) |-> cmd_ready)
		else $error("input stalled while block is empty");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the rdp state command decoder core
module tb;
	import rsd_pkg::*;

	localparam int NUM_RANDOM  = 1600;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	rsd_in_t  cmd = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	rsd_out_t rsp;

	rdp_state_command_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// commands waiting to go out, and results the render-state mirror expects
	rsd_in_t  pending_cmds[$];
	rsd_out_t expected_rsps[$];
	int       total_cmds = 0;
	int       accepted_cmds = 0;
	int       error_count = 0;

	// mirror of the render-state register file
	logic [63:0] rs_words [NUM_WORDS];
	logic [31:0] rs_epoch;
	logic [31:0] rs_sync_count [NUM_SYNCS];
	logic [31:0] rs_sync_tag [NUM_SYNCS];
	logic [FLAG_BITS-1:0] rs_flags;
	logic [31:0] rs_last_tag;

	task automatic clear_render_state();
		for (int i = 0; i < NUM_WORDS; i++) rs_words[i] = '0;
		for (int i = 0; i < NUM_SYNCS; i++) begin
			rs_sync_count[i] = '0;
			rs_sync_tag[i] = '0;
		end
		rs_epoch = '0;
		rs_flags = '0;
		rs_last_tag = '0;
	endtask

	task automatic store_word(input logic [3:0] kind, input logic [63:0] value);
		rs_words[kind] = value;
		rs_flags[{1'b0, kind}] = 1'b1;
	endtask

	// carry one accepted command through the mirror and queue its result
	task automatic decode_and_predict(input rsd_in_t c);
		logic [31:0] w0;
		logic [31:0] w1;
		logic [12:0] width_p1;
		logic [1:0]  s;
		logic [1:0]  sidx;
		rsd_out_t    r;
		w0 = c.word_high;
		w1 = c.word_low;
		r = '0;
		if (c.operation == OPR_APPLY && c.is_rdp) begin
			case (c.opcode)
				OPC_OTHER_MODES: store_word(KIND_OTHER_MODES, {8'd0, w0[23:0], w1});
				OPC_COMBINE:     store_word(KIND_COMBINE, {8'd0, w0[23:0], w1});
				OPC_SCISSOR: begin
					// edges drop the two fraction bits
					store_word(KIND_SCISSOR, {22'd0, w1[25:24], w0[23:14], w0[11:2],
						w1[23:14], w1[11:2]});
				end
				OPC_COLOR_IMAGE: begin
					width_p1 = {1'b0, w0[11:0]} + 13'd1;
					store_word(KIND_COLOR_IMAGE, {22'd0, w0[23:21], w0[20:19], width_p1,
						w1[23:0]});
				end
				OPC_DEPTH_IMAGE: store_word(KIND_DEPTH_IMAGE, {40'd0, w1[23:0]});
				OPC_PRIM_COLOR:  store_word(KIND_PRIM_COLOR, {19'd0, w0[12:8], w0[7:0], w1});
				OPC_ENV_COLOR:   store_word(KIND_ENV_COLOR, {32'd0, w1});
				OPC_BLEND_COLOR: store_word(KIND_BLEND_COLOR, {32'd0, w1});
				OPC_FOG_COLOR:   store_word(KIND_FOG_COLOR, {32'd0, w1});
				OPC_FILL_COLOR:  store_word(KIND_FILL_COLOR, {32'd0, w1});
				OPC_PRIM_DEPTH:  store_word(KIND_PRIM_DEPTH, {32'd0, w1});
				OPC_CONVERT: begin
					// k2 straddles the two command words
					store_word(KIND_CONVERT, {10'd0, w0[21:13], w0[12:4], w0[3:0],
						w1[31:27], w1[26:0]});
				end
				OPC_KEY_R:  store_word(KIND_KEY_R, {36'd0, w1[27:0]});
				OPC_KEY_GB: store_word(KIND_KEY_GB, {8'd0, w0[23:0], w1});
				OPC_LOAD_SYNC, OPC_PIPE_SYNC, OPC_TILE_SYNC, OPC_FULL_SYNC: begin
					s = 2'(c.opcode - OPC_LOAD_SYNC);
					rs_epoch = rs_epoch + 32'd1;
					rs_sync_count[s] = rs_sync_count[s] + 32'd1;
					rs_sync_tag[s] = c.packet_tag;
					rs_flags[5'(SYNC_FLAG_BASE) + {3'd0, s}] = 1'b1;
				end
				default: ;
			endcase
			rs_last_tag = c.packet_tag;
		end else if (c.operation == OPR_READ) begin
			if (c.read_index < NUM_WORDS)
				r.read_data = rs_words[c.read_index[3:0]];
			else if (c.read_index == IDX_EPOCH)
				r.read_data = {32'd0, rs_epoch};
			else if (c.read_index <= IDX_SYNC_LAST) begin
				sidx = 2'(c.read_index - IDX_SYNC_FIRST);
				r.read_data = {rs_sync_count[sidx], rs_sync_tag[sidx]};
			end
		end else if (c.operation == OPR_CLEAR) begin
			clear_render_state();
		end
		r.changed_flags_out = rs_flags;
		r.epoch_out = rs_epoch;
		r.last_tag_out = rs_last_tag;
		r.cycle_mode = rs_words[KIND_OTHER_MODES][53:52];
		expected_rsps.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	function automatic rsd_in_t make_cmd(input logic [1:0] op, input logic rdp,
		input logic [7:0] opc, input logic [31:0] w0, input logic [31:0] w1,
		input logic [31:0] tag, input logic [4:0] idx);
		rsd_in_t c;
		c.operation = op;
		c.is_rdp = rdp;
		c.opcode = opc;
		c.word_high = w0;
		c.word_low = w1;
		c.packet_tag = tag;
		c.read_index = idx;
		return c;
	endfunction

	function automatic logic [7:0] pick_known_opcode();
		case ($urandom_range(0, 17))
			0:  return OPC_OTHER_MODES;
			1:  return OPC_COMBINE;
			2:  return OPC_SCISSOR;
			3:  return OPC_COLOR_IMAGE;
			4:  return OPC_DEPTH_IMAGE;
			5:  return OPC_PRIM_COLOR;
			6:  return OPC_ENV_COLOR;
			7:  return OPC_BLEND_COLOR;
			8:  return OPC_FOG_COLOR;
			9:  return OPC_FILL_COLOR;
			10: return OPC_PRIM_DEPTH;
			11: return OPC_CONVERT;
			12: return OPC_KEY_R;
			13: return OPC_KEY_GB;
			14: return OPC_LOAD_SYNC;
			15: return OPC_PIPE_SYNC;
			16: return OPC_TILE_SYNC;
			default: return OPC_FULL_SYNC;
		endcase
	endfunction

	// mostly real state commands and reads, with noise, clears and no-ops mixed in
	function automatic rsd_in_t random_cmd();
		rsd_in_t c;
		int pick;
		c = make_cmd(2'($urandom), 1'($urandom), 8'($urandom), $urandom, $urandom,
			$urandom, 5'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			c.operation = OPR_APPLY;
			c.is_rdp = 1'b1;
			c.opcode = pick_known_opcode();
		end else if (pick < 58) begin
			c.operation = OPR_APPLY;
			c.is_rdp = 1'b1;
		end else if (pick < 63) begin
			c.operation = OPR_APPLY;
			c.is_rdp = 1'b0;
		end else if (pick < 95) begin
			c.operation = OPR_READ;
			c.read_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
				: 5'($urandom_range(0, 18));
		end else if (pick < 97) begin
			c.operation = 2'd3;
		end else begin
			c.operation = OPR_CLEAR;
		end
		return c;
	endfunction

	// stimulus, then drain and verdict
	initial begin
		logic [7:0] word_opcodes [NUM_WORDS];
		word_opcodes[0]  = OPC_OTHER_MODES;
		word_opcodes[1]  = OPC_COMBINE;
		word_opcodes[2]  = OPC_SCISSOR;
		word_opcodes[3]  = OPC_COLOR_IMAGE;
		word_opcodes[4]  = OPC_DEPTH_IMAGE;
		word_opcodes[5]  = OPC_PRIM_COLOR;
		word_opcodes[6]  = OPC_ENV_COLOR;
		word_opcodes[7]  = OPC_BLEND_COLOR;
		word_opcodes[8]  = OPC_FOG_COLOR;
		word_opcodes[9]  = OPC_FILL_COLOR;
		word_opcodes[10] = OPC_PRIM_DEPTH;
		word_opcodes[11] = OPC_CONVERT;
		word_opcodes[12] = OPC_KEY_R;
		word_opcodes[13] = OPC_KEY_GB;
		clear_render_state();

		// every state word with all ones, which also tops out the color image width
		for (int i = 0; i < NUM_WORDS; i++)
			pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, word_opcodes[i],
				32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(i), 5'd0));
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, OPC_LOAD_SYNC, '0, '0,
			32'hFFFF_FFFF, 5'd0));
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, OPC_PIPE_SYNC, '1, '1, '0, 5'd0));
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, OPC_TILE_SYNC, '0, '1,
			32'h8000_0001, 5'd0));
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, OPC_FULL_SYNC, '1, '0,
			32'h1234_5678, 5'd0));
		// packet outside the rdp domain leaves everything alone
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b0, OPC_OTHER_MODES, '0, '0,
			32'hDEAD_BEEF, 5'd0));
		// unknown opcode moves only the last tag
		pending_cmds.push_back(make_cmd(OPR_APPLY, 1'b1, 8'hFF, '1, '1, 32'h0BAD_F00D, 5'd0));
		pending_cmds.push_back(make_cmd(2'd3, 1'b1, OPC_FULL_SYNC, '1, '1, '1, 5'd15));
		pending_cmds.push_back(make_cmd(OPR_READ, 1'b0, '0, '0, '0, '0, 5'd31));
		pending_cmds.push_back(make_cmd(OPR_READ, 1'b1, '1, '1, '1, '1, 5'd19));
		pending_cmds.push_back(make_cmd(OPR_READ, 1'b0, '0, '0, '0, '0, 5'd0));
		pending_cmds.push_back(make_cmd(OPR_CLEAR, 1'b1, OPC_LOAD_SYNC, '1, '1, '1, 5'd18));

		for (int i = 0; i < NUM_RANDOM; i++)
			pending_cmds.push_back(random_cmd());
		total_cmds = pending_cmds.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cmds < total_cmds || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// command driver: bursts of random length, random gaps between them
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				decode_and_predict(cmd);
				accepted_cmds++;
			end
			// a new transfer may only be offered once the current one is gone
			if (!cmd_valid || cmd_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 32);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stretches of always ready, random, alternating or stalled
	int stall_mode = 0;
	int stretch_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_mode <= 0;
			stretch_left <= 0;
		end else begin
			if (stretch_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stretch_left <= $urandom_range(4, 60);
			end else begin
				stretch_left <= stretch_left - 1;
			end
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ready <= ~rsp_ready;
				default: rsp_ready <= (stretch_left < 3);
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsd_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected result read_data", rsp.read_data, '0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.read_data !== want.read_data)
					report_mismatch("read_data", rsp.read_data, want.read_data);
				if (rsp.changed_flags_out !== want.changed_flags_out)
					report_mismatch("changed_flags_out", 64'(rsp.changed_flags_out),
						64'(want.changed_flags_out));
				if (rsp.epoch_out !== want.epoch_out)
					report_mismatch("epoch_out", 64'(rsp.epoch_out), 64'(want.epoch_out));
				if (rsp.last_tag_out !== want.last_tag_out)
					report_mismatch("last_tag_out", 64'(rsp.last_tag_out),
						64'(want.last_tag_out));
				if (rsp.cycle_mode !== want.cycle_mode)
					report_mismatch("cycle_mode", 64'(rsp.cycle_mode), 64'(want.cycle_mode));
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

// ===== rdp_state_command_decoder_core.f =====
sv/rsd_pkg.sv
sv/rsd_front.sv
sv/rsd_queue.sv
sv/rsd_back.sv
sv/rdp_state_command_decoder_core.sv
verif/tb.sv
